// File: hw/rtl/weighted_deficit_round_robin_defines.svh
// ----------------------------------------------------------------------------
// Weighted deficit round robin assertion macros
// Shared property forms for the scheduler checks.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_DEFICIT_ROUND_ROBIN_DEFINES_SVH
`define WEIGHTED_DEFICIT_ROUND_ROBIN_DEFINES_SVH

// same-cycle implication
`define WDRR_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WDRR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/wdrr_pkg.sv
// ----------------------------------------------------------------------------
// Weighted deficit round robin package
// Sizes, register indexes, sequencer states and helpers.
// ----------------------------------------------------------------------------
package wdrr_pkg;

    localparam int NUM_CLASSES = 4;
    localparam int MAX_CLASSES = 4;
    localparam int CREDIT_BITS = 24;
    localparam int CLS_W       = (NUM_CLASSES > 2) ? 2 : 1;
    localparam int CNT_W       = $clog2(NUM_CLASSES + 1);
    localparam int GRANT_CLS_W = 2;
    localparam int LEN_W       = 16;
    localparam int DEFICIT_W   = 16;
    localparam int WEIGHT_W    = 8;
    localparam int WEIGHTS_W   = 32;
    localparam int SUM_W       = WEIGHT_W + 2;
    localparam int PROD_W      = WEIGHT_W + DEFICIT_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [DEFICIT_W-1:0] DEFICIT_RESET = DEFICIT_W'(1500);
    localparam logic [WEIGHTS_W-1:0] WEIGHTS_RESET = 32'h0101_0101;

    localparam logic [CFG_IDX_W-1:0] REG_ROUND_DEFICIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_WEIGHTS = CFG_IDX_W'(1);

    typedef logic [CREDIT_BITS-1:0] credit_t;
    typedef logic [LEN_W-1:0]       len_t;
    typedef logic [DEFICIT_W-1:0]   quantum_t;

    typedef enum logic [2:0] {
        ST_MUL,
        ST_DSTART,
        ST_DIV,
        ST_IDLE,
        ST_TRY,
        ST_REPL,
        ST_DONE
    } state_t;

    function automatic credit_t sat_add(input credit_t a, input quantum_t b);
        logic [CREDIT_BITS:0] s;
        begin
            s = {1'b0, a} + {{(CREDIT_BITS + 1 - DEFICIT_W){1'b0}}, b};
            sat_add = s[CREDIT_BITS] ? {CREDIT_BITS{1'b1}} : s[CREDIT_BITS-1:0];
        end
    endfunction

endpackage

// File: hw/rtl/wdrr_div.sv
// ----------------------------------------------------------------------------
// Weighted deficit round robin divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wdrr_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [wdrr_pkg::PROD_W-1:0] numer,
    input  logic [wdrr_pkg::SUM_W-1:0]  denom,
    output logic                        done,
    output logic [wdrr_pkg::PROD_W-1:0] quot
);
    import wdrr_pkg::*;

    localparam int ITER_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] num_reg, num_next;
    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  den_reg, den_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [SUM_W:0]    trial;

    assign trial = {rem_reg, num_reg[PROD_W-1]};

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next = numer;
            rem_next = '0;
            den_next = denom;
            cnt_next = ITER_W'(PROD_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = SUM_W'(trial - {1'b0, den_reg});
                num_next = {num_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[SUM_W-1:0];
                num_next = {num_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - ITER_W'(1);
            if (cnt_reg == ITER_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

// File: hw/rtl/weighted_deficit_round_robin.sv
// ----------------------------------------------------------------------------
// Weighted deficit round robin scheduler
// Four-class credit scheduler with per-round weighted replenishment.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel: raise start with func and head_len_0..3 while busy is low;
//   the item is taken at that edge and busy rises. Each item returns one
//   result: done pulses for a single cycle with granted, grant_class and
//   grant_len. The receiver cannot stall; the result must be taken then.
//   Sequence: after the accepting edge the block passes through a TRY state
//   for each class tried, a REPL state for the replenish on a wrap, and a
//   DONE state that presents the result; busy drops right after done.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data. A write
//   reruns the per-class quantum calculation: one multiply and a 24-step
//   serial divide per class, with busy held high throughout.
//   Reset: credits and pointer clear, registers take their defaults and the
//   quantum calculation runs once before the first item is taken.
// ----------------------------------------------------------------------------
`include "weighted_deficit_round_robin_defines.svh"

module weighted_deficit_round_robin
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                func,
    input  logic [wdrr_pkg::LEN_W-1:0]          head_len_0,
    input  logic [wdrr_pkg::LEN_W-1:0]          head_len_1,
    input  logic [wdrr_pkg::LEN_W-1:0]          head_len_2,
    input  logic [wdrr_pkg::LEN_W-1:0]          head_len_3,
    output logic                                done,
    output logic                                granted,
    output logic [wdrr_pkg::GRANT_CLS_W-1:0]    grant_class,
    output logic [wdrr_pkg::LEN_W-1:0]          grant_len,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wdrr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wdrr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import wdrr_pkg::*;

    localparam logic [CLS_W-1:0] LAST_CLS = CLS_W'(NUM_CLASSES - 1);

    state_t state_reg, state_next;

    logic [DEFICIT_W-1:0] round_deficit_reg, round_deficit_next;
    logic [WEIGHTS_W-1:0] class_weights_reg, class_weights_next;
    credit_t              credit_reg [NUM_CLASSES];
    credit_t              credit_next [NUM_CLASSES];
    credit_t              work_reg [NUM_CLASSES];
    credit_t              work_next [NUM_CLASSES];
    quantum_t             quantum_reg [NUM_CLASSES];
    quantum_t             quantum_next [NUM_CLASSES];
    len_t                 lens_reg [NUM_CLASSES];
    len_t                 lens_next [NUM_CLASSES];
    len_t                 head_in [MAX_CLASSES];
    logic [CLS_W-1:0]     round_pointer_reg, round_pointer_next;
    logic [CLS_W-1:0]     ptr_reg, ptr_next;
    logic [CLS_W-1:0]     cidx_reg, cidx_next;
    logic [CNT_W-1:0]     tries_reg, tries_next;
    logic                 func_reg, func_next;
    logic                 granted_reg, granted_next;
    logic [CLS_W-1:0]     gcls_reg, gcls_next;
    len_t                 glen_reg, glen_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;

    logic                 cfg_we;
    logic                 div_start;
    logic                 div_done;
    logic [PROD_W-1:0]    div_quot;
    logic [SUM_W-1:0]     weight_sum;
    logic [WEIGHT_W-1:0]  cur_weight;
    len_t                 cur_len;
    credit_t              cur_credit;
    logic                 hit;

    assign head_in[0] = head_len_0;
    assign head_in[1] = head_len_1;
    assign head_in[2] = head_len_2;
    assign head_in[3] = head_len_3;

    always_comb
    begin
        weight_sum = '0;
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            weight_sum = weight_sum
                + SUM_W'(class_weights_reg[i*WEIGHT_W +: WEIGHT_W]);
        end
    end

    assign cur_weight = class_weights_reg[cidx_reg*WEIGHT_W +: WEIGHT_W];
    assign cur_len    = lens_reg[ptr_reg];
    assign cur_credit = work_reg[ptr_reg];
    assign hit = (cur_len != '0)
        && ({{(CREDIT_BITS - LEN_W){1'b0}}, cur_len} <= cur_credit);

    assign cfg_we = cfg_valid && cfg_ready;

    wdrr_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (prod_reg),
        .denom (weight_sum),
        .done  (div_done),
        .quot  (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_MUL:
            begin
                if (!cfg_we)
                    state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                state_next = cfg_we ? ST_MUL : ST_DIV;
            end
            ST_DIV:
            begin
                if (cfg_we)
                    state_next = ST_MUL;
                else if (div_done)
                    state_next = (cidx_reg == LAST_CLS) ? ST_IDLE : ST_MUL;
            end
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_TRY;
                else if (cfg_we)
                    state_next = ST_MUL;
            end
            ST_TRY:
            begin
                if (ptr_reg == LAST_CLS)
                    state_next = ST_REPL;
                else if (hit || tries_reg == CNT_W'(NUM_CLASSES - 1))
                    state_next = ST_DONE;
            end
            ST_REPL:
            begin
                if (granted_reg || tries_reg == CNT_W'(NUM_CLASSES))
                    state_next = ST_DONE;
                else
                    state_next = ST_TRY;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        busy      = 1'b1;
        done      = 1'b0;
        cfg_ready = 1'b1;
        div_start = 1'b0;
        unique case (state_reg)
            ST_MUL, ST_DIV:
            begin
            end
            ST_DSTART:
            begin
                div_start = 1'b1;
            end
            ST_IDLE:
            begin
                busy      = 1'b0;
                cfg_ready = !start;
            end
            ST_TRY, ST_REPL:
            begin
                cfg_ready = 1'b0;
            end
            ST_DONE:
            begin
                done      = 1'b1;
                cfg_ready = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // datapath
    always_comb
    begin
        round_deficit_next = round_deficit_reg;
        class_weights_next = class_weights_reg;
        round_pointer_next = round_pointer_reg;
        ptr_next           = ptr_reg;
        cidx_next          = cidx_reg;
        tries_next         = tries_reg;
        func_next          = func_reg;
        granted_next       = granted_reg;
        gcls_next          = gcls_reg;
        glen_next          = glen_reg;
        prod_next          = prod_reg;
        credit_next        = credit_reg;
        work_next          = work_reg;
        quantum_next       = quantum_reg;
        lens_next          = lens_reg;

        if (cfg_we)
        begin
            cidx_next = '0;
            case (cfg_index)
                REG_ROUND_DEFICIT: round_deficit_next = cfg_data[DEFICIT_W-1:0];
                REG_CLASS_WEIGHTS: class_weights_next = cfg_data[WEIGHTS_W-1:0];
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            ST_MUL:
            begin
                prod_next = cur_weight * round_deficit_reg;
            end
            ST_DIV:
            begin
                if (div_done && !cfg_we)
                begin
                    quantum_next[cidx_reg] = (weight_sum == '0) ? '0
                        : div_quot[DEFICIT_W-1:0];
                    cidx_next = cidx_reg + CLS_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next    = func;
                    ptr_next     = round_pointer_reg;
                    tries_next   = '0;
                    granted_next = 1'b0;
                    gcls_next    = '0;
                    glen_next    = '0;
                    work_next    = credit_reg;
                    for (int i = 0; i < NUM_CLASSES; i++)
                        lens_next[i] = head_in[i];
                end
            end
            ST_TRY:
            begin
                if (hit)
                begin
                    work_next[ptr_reg] = cur_credit
                        - {{(CREDIT_BITS - LEN_W){1'b0}}, cur_len};
                    granted_next = 1'b1;
                    gcls_next    = ptr_reg;
                    glen_next    = cur_len;
                end
                else
                begin
                    tries_next = tries_reg + CNT_W'(1);
                end
                ptr_next = (ptr_reg == LAST_CLS) ? '0 : ptr_reg + CLS_W'(1);
            end
            ST_REPL:
            begin
                for (int i = 0; i < NUM_CLASSES; i++)
                    work_next[i] = sat_add(work_reg[i], quantum_reg[i]);
            end
            ST_DONE:
            begin
                if (!func_reg)
                begin
                    credit_next        = work_reg;
                    round_pointer_next = ptr_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_MUL;
            round_deficit_reg <= DEFICIT_RESET;
            class_weights_reg <= WEIGHTS_RESET;
            round_pointer_reg <= '0;
            cidx_reg          <= '0;
            tries_reg         <= '0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                credit_reg[i]  <= '0;
                quantum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg         <= state_next;
            round_deficit_reg <= round_deficit_next;
            class_weights_reg <= class_weights_next;
            round_pointer_reg <= round_pointer_next;
            cidx_reg          <= cidx_next;
            tries_reg         <= tries_next;
            credit_reg        <= credit_next;
            quantum_reg       <= quantum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        func_reg    <= func_next;
        granted_reg <= granted_next;
        gcls_reg    <= gcls_next;
        glen_reg    <= glen_next;
        prod_reg    <= prod_next;
        work_reg    <= work_next;
        lens_reg    <= lens_next;
    end

    assign granted     = granted_reg;
    assign grant_class = GRANT_CLS_W'(gcls_reg);
    assign grant_len   = glen_reg;

    `WDRR_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done && !busy, "done held or busy after result")
    `WDRR_ASSERT_NOW(a_miss_clear, clk, rst_n, done && !granted, grant_len == '0 && grant_class == '0, "miss result not cleared")
    `WDRR_ASSERT_NOW(a_grant_len, clk, rst_n, done && granted, grant_len != '0, "grant of an empty class")
    `WDRR_ASSERT_NEXT(a_peek_keeps, clk, rst_n, done && func_reg, $stable(round_pointer_reg), "peek moved the pointer")

endmodule
